// File: src/assert_macros.svh
// assertion macros shared by the scoreboard modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("scoreboard assertion failed");

`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("scoreboard forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)

`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// File: src/rsbs_pkg.sv
// types and constants of the register scoreboard with borrow stack
package rsbs_pkg;

    localparam int REG_SPACE   = 16;
    localparam int REG_W       = 4;
    localparam int STACK_SLOTS = 16;
    localparam int STACK_AW    = 4;
    localparam int DEPTH_W     = 5;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 16;

    typedef enum logic [3:0] {
        OP_USED     = 4'd0,
        OP_UNUSED   = 4'd1,
        OP_BORROW   = 4'd2,
        OP_RELEASE  = 4'd3,
        OP_ANY      = 4'd4,
        OP_EXCL     = 4'd5,
        OP_SHARED   = 4'd6,
        OP_SPECIFIC = 4'd7,
        OP_HELD     = 4'd8,
        OP_QUERY    = 4'd9
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_OCCUPIED     = 3'd1,
        ST_BORROWED     = 3'd2,
        ST_NOT_OCCUPIED = 3'd3,
        ST_NOT_BORROWED = 3'd4,
        ST_ORDER        = 3'd5,
        ST_NONE         = 3'd6
    } t_status;

    typedef struct packed {
        logic              pad;
        logic              held_evicted;
        logic              held_borrowed;
        logic [REG_SPACE-1:0] allow_mask;
        logic [REG_W-1:0]  alloc_reg;
        logic              alloc_is_gpr;
        logic [REG_W-1:0]  reg_index;
        logic [3:0]        opcode;
    } t_request;

    typedef struct packed {
        logic [1:0]       pad;
        logic             any_borrowed;
        logic             reg_borrowed;
        logic             reg_occupied;
        logic             emit_pop;
        logic             emit_push;
        logic             granted_evicted;
        logic             granted_borrowed;
        logic [REG_W-1:0] granted_reg;
        logic [2:0]       status;
    } t_result;

    typedef struct packed {
        logic load;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic             found;
        logic [REG_W-1:0] idx;
    } t_pick;

    function automatic t_pick lowest_set(input logic [REG_SPACE-1:0] m);
        t_pick p;
        p = '0;
        for (int i = REG_SPACE - 1; i >= 0; i--) begin
            if (m[i]) begin
                p.found = 1'b1;
                p.idx   = REG_W'(i);
            end
        end
        return p;
    endfunction

endpackage

// File: src/rsbs_ctrl.sv
// request sequencing and result slot control
`include "assert_macros.svh"

module rsbs_ctrl
    import rsbs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    output logic    o_m_tvalid,
    input  logic    i_m_tready,
    output t_dp_cmd o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   slot_free;

    assign slot_free    = !r_out_valid || i_m_tready;
    assign o_s_tready   = (r_state == S_IDLE);
    assign o_m_tvalid   = r_out_valid;
    assign o_cmd.load   = (r_state == S_IDLE) && i_s_tvalid;
    assign o_cmd.commit = (r_state == S_EXEC) && slot_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_state <= S_EXEC;
                    end
                    if (i_m_tready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                S_EXEC: begin
                    if (slot_free) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `ASSERT_PROP(a_load_enters_exec, i_clk, i_rst_n, o_cmd.load |=> (r_state == S_EXEC))
    `ASSERT_NEVER(a_no_overwrite, i_clk, i_rst_n, r_out_valid && !i_m_tready && o_cmd.commit)
    `ASSERT_PROP(a_result_held, i_clk, i_rst_n, (o_m_tvalid && !i_m_tready) |=> o_m_tvalid)

endmodule

// File: src/rsbs_datapath.sv
// scoreboard maps, borrow stack and request evaluation
`include "assert_macros.svh"

module rsbs_datapath
    import rsbs_pkg::*;
#(
    parameter int NUM_REGS = 16
)
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_dp_cmd  i_cmd,
    input  t_request i_req,
    output t_result  o_result
);

    localparam int MAP_W = (NUM_REGS < REG_SPACE) ? NUM_REGS : REG_SPACE;

    t_request            r_req;
    logic [MAP_W-1:0]    r_occ;
    logic [MAP_W-1:0]    r_bor;
    logic [DEPTH_W-1:0]  r_depth;
    logic [REG_W-1:0]    r_stack [STACK_SLOTS];
    logic [REG_W-1:0]    r_top;
    t_result             r_out;

    logic [REG_SPACE-1:0] valid_map;
    logic [REG_SPACE-1:0] occ_ext;
    logic [REG_SPACE-1:0] bor_ext;
    logic [REG_SPACE-1:0] allowed;
    logic [REG_SPACE-1:0] n_occ_ext;
    logic [REG_SPACE-1:0] n_bor_ext;
    t_pick                pick_free;
    t_pick                pick_spill;
    logic                 any_ok;
    logic [REG_W-1:0]     any_reg;
    logic                 any_evict;
    logic                 alloc_ok;
    t_status              rel_status;
    t_status              st;
    t_opcode              op;
    logic [REG_W-1:0]     r_idx;
    logic                 do_push;
    logic                 do_pop;
    logic [REG_W-1:0]     push_reg;
    t_result              res;

    always_comb begin
        for (int i = 0; i < REG_SPACE; i++) begin
            valid_map[i] = (i < NUM_REGS);
        end
    end

    assign occ_ext    = REG_SPACE'(r_occ);
    assign bor_ext    = REG_SPACE'(r_bor);
    assign allowed    = r_req.allow_mask & valid_map;
    assign pick_free  = lowest_set(allowed & ~occ_ext & ~bor_ext);
    assign pick_spill = lowest_set(allowed & ~bor_ext);
    assign any_ok     = pick_free.found || pick_spill.found;
    assign any_evict  = !pick_free.found;
    assign any_reg    = pick_free.found ? pick_free.idx : pick_spill.idx;
    assign op         = t_opcode'(r_req.opcode);
    assign r_idx      = r_req.reg_index;
    assign alloc_ok   = r_req.alloc_is_gpr && valid_map[r_req.alloc_reg]
                        && r_req.allow_mask[r_req.alloc_reg] && !bor_ext[r_req.alloc_reg];

    always_comb begin
        if (!bor_ext[r_idx] || (r_depth == '0)) begin
            rel_status = ST_NOT_BORROWED;
        end else if (r_top != r_idx) begin
            rel_status = ST_ORDER;
        end else begin
            rel_status = ST_OK;
        end
    end

    always_comb begin
        res       = '0;
        st        = ST_OK;
        do_push   = 1'b0;
        do_pop    = 1'b0;
        push_reg  = r_idx;
        n_occ_ext = occ_ext;
        n_bor_ext = bor_ext;
        unique case (op) inside
            OP_USED: begin
                if (!valid_map[r_idx]) begin
                    st = ST_NONE;
                end else if (occ_ext[r_idx]) begin
                    st = ST_OCCUPIED;
                end else if (bor_ext[r_idx]) begin
                    st = ST_BORROWED;
                end else begin
                    n_occ_ext[r_idx] = 1'b1;
                end
            end
            OP_UNUSED: begin
                if (!occ_ext[r_idx]) begin
                    st = ST_NOT_OCCUPIED;
                end else if (bor_ext[r_idx]) begin
                    st = ST_BORROWED;
                end else begin
                    n_occ_ext[r_idx] = 1'b0;
                end
            end
            OP_BORROW: begin
                if (!valid_map[r_idx]) begin
                    st = ST_NONE;
                end else if (bor_ext[r_idx]) begin
                    st = ST_BORROWED;
                end else begin
                    do_push = 1'b1;
                end
            end
            OP_RELEASE: begin
                st     = rel_status;
                do_pop = (rel_status == ST_OK);
            end
            OP_ANY, OP_EXCL, OP_SHARED: begin
                if ((op != OP_ANY) && alloc_ok) begin
                    res.granted_reg = r_req.alloc_reg;
                    if (op == OP_EXCL) begin
                        do_push              = 1'b1;
                        push_reg             = r_req.alloc_reg;
                        res.granted_borrowed = 1'b1;
                    end
                end else if (any_ok) begin
                    do_push              = 1'b1;
                    push_reg             = any_reg;
                    res.granted_reg      = any_reg;
                    res.granted_borrowed = 1'b1;
                    res.granted_evicted  = any_evict;
                    res.emit_push        = any_evict;
                end else begin
                    st = ST_NONE;
                end
            end
            OP_SPECIFIC: begin
                if (!valid_map[r_idx]) begin
                    st = ST_NONE;
                end else if (bor_ext[r_idx]) begin
                    st = ST_BORROWED;
                end else begin
                    do_push              = 1'b1;
                    res.granted_reg      = r_idx;
                    res.granted_borrowed = 1'b1;
                    res.granted_evicted  = occ_ext[r_idx];
                    res.emit_push        = occ_ext[r_idx];
                end
            end
            OP_HELD: begin
                if (r_req.held_borrowed) begin
                    st     = rel_status;
                    do_pop = (rel_status == ST_OK);
                end
                if (st == ST_OK) begin
                    res.emit_pop = r_req.held_evicted;
                end
            end
            OP_QUERY: begin
                res.reg_occupied = occ_ext[r_idx];
                res.reg_borrowed = bor_ext[r_idx];
            end
            default: begin
                st = ST_OK;
            end
        endcase
        if (do_push) begin
            n_bor_ext[push_reg] = 1'b1;
        end
        if (do_pop) begin
            n_bor_ext[r_idx] = 1'b0;
        end
        res.status       = st;
        res.any_borrowed = (n_bor_ext != '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.commit) begin
            r_out <= res;
        end
        if (i_cmd.commit && do_push && (r_depth < DEPTH_W'(STACK_SLOTS))) begin
            r_stack[r_depth[STACK_AW-1:0]] <= push_reg;
        end
        r_top <= r_stack[r_depth[STACK_AW-1:0] - 1'b1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ   <= '0;
            r_bor   <= '0;
            r_depth <= '0;
        end else if (i_cmd.commit) begin
            r_occ <= n_occ_ext[MAP_W-1:0];
            r_bor <= n_bor_ext[MAP_W-1:0];
            if (do_push && (r_depth < DEPTH_W'(STACK_SLOTS))) begin
                r_depth <= r_depth + 1'b1;
            end else if (do_pop) begin
                r_depth <= r_depth - 1'b1;
            end
        end
    end

    assign o_result = r_out;

    `ASSERT_PROP(a_depth_bound, i_clk, i_rst_n, r_depth <= DEPTH_W'(STACK_SLOTS))
    `ASSERT_PROP(a_depth_matches_map, i_clk, i_rst_n, $countones(r_bor) == int'(r_depth))
    `ASSERT_PROP(a_any_borrowed, i_clk, i_rst_n, i_cmd.commit |=> (r_out.any_borrowed == (r_bor != '0)))

endmodule

// File: src/register_scoreboard_borrow_stack_top.sv
// top level of the register scoreboard with borrow stack
//
// channel   direction  handshake            payload
// request   in         i_s_tvalid/o_s_tready i_s_tdata, 32 bits
// result    out        o_m_tvalid/i_m_tready o_m_tdata, 16 bits
//
// each request is first registered, then evaluated to update the maps
// a request is taken while a previous result still waits in the output register
// evaluation holds while the output register is full and not being taken
// synchronous active-low reset clears the maps, stack depth and handshake state
module register_scoreboard_borrow_stack_top
    import rsbs_pkg::*;
#(
    parameter int NUM_REGS = 16
)
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // opcode, reg_index, alloc_is_gpr, alloc_reg, allow_mask, held_borrowed, held_evicted
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // status, granted_reg, granted_borrowed, granted_evicted, emit_push, emit_pop,
    // reg_occupied, reg_borrowed, any_borrowed
    output logic [OUT_TDATA_W-1:0] o_m_tdata
);

    t_dp_cmd cmd;
    t_result result;

    rsbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (cmd)
    );

    rsbs_datapath #(
        .NUM_REGS (NUM_REGS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_req    (t_request'(i_s_tdata)),
        .o_result (result)
    );

    assign o_m_tdata = OUT_TDATA_W'(result);

endmodule
